// ===== hw/rtl/pfc_pkg.sv =====
// pfc_pkg: shared types, constants and letter/cell helpers for the playfair block
// used by playfair_digraph_cipher; depends on nothing

package pfc_pkg;

   localparam int LETTERS  = 26;
   localparam int CELLS    = 25;
   localparam int LETTER_W = 5;
   localparam int CELL_W   = 5;

   localparam logic [LETTER_W-1:0] LETTER_I  = 5'd8;
   localparam logic [LETTER_W-1:0] LETTER_J  = 5'd9;
   localparam logic [LETTER_W-1:0] LETTER_X  = 5'd23;
   localparam logic [LETTER_W-1:0] LETTER_Z  = 5'd25;
   localparam logic [CELL_W-1:0]   FILL_FULL = 5'd25;
   localparam logic [6:0]          ASCII_LOWER_A = 7'd97;

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_KEY    = 3'd1,
      CMD_FINISH = 3'd2,
      CMD_TEXT   = 3'd3,
      CMD_END    = 3'd4
   } cmd_type;

   typedef struct packed {
      logic                ok;
      logic [LETTER_W-1:0] idx;
   } letter_type;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } rc_type;

   // ascii byte to letter index, either case
   function automatic letter_type decode_letter(input logic [7:0] ch);
      letter_type r;
      logic [7:0] d;
      r = '0;
      d = '0;
      if (ch >= 8'h61 && ch <= 8'h7a) begin
         d     = ch - 8'h61;
         r.ok  = 1'b1;
         r.idx = d[4:0];
      end else if (ch >= 8'h41 && ch <= 8'h5a) begin
         d     = ch - 8'h41;
         r.ok  = 1'b1;
         r.idx = d[4:0];
      end
      return r;
   endfunction

   function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] l);
      return (l == LETTER_J) ? LETTER_I : l;
   endfunction

   // cell 0..24 to row and column
   function automatic rc_type split_cell(input logic [CELL_W-1:0] p);
      rc_type r;
      logic [CELL_W-1:0] col5;
      if (p >= 5'd20)      r.row = 3'd4;
      else if (p >= 5'd15) r.row = 3'd3;
      else if (p >= 5'd10) r.row = 3'd2;
      else if (p >= 5'd5)  r.row = 3'd1;
      else                 r.row = 3'd0;
      col5  = p - {r.row, 2'b00} - {2'b00, r.row};
      r.col = col5[2:0];
      return r;
   endfunction

   // one step around the side of the square, forward or back
   function automatic logic [2:0] step5(input logic [2:0] x, input logic back);
      logic [2:0] r;
      if (back) r = (x == 3'd0) ? 3'd4 : x - 3'd1;
      else      r = (x == 3'd4) ? 3'd0 : x + 3'd1;
      return r;
   endfunction

   function automatic logic [CELL_W-1:0] cell_at(input logic [2:0] row, input logic [2:0] col);
      return {row, 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

endpackage

// ===== hw/rtl/playfair_digraph_cipher.sv =====
// playfair_digraph_cipher: playfair cipher over a 5x5 key square held in two rams
// depends on pfc_pkg and pfc_ram

// usage
//   request channel (req_valid / req_stall / req_cmd / req_char_in) carries one
//   command per transaction: clear key, key character, finish key, text
//   character, end of message. req_stall is high while a command is in work.
//   response channel (rsp_valid / rsp_stall / rsp_first_letter /
//   rsp_second_letter) carries one coded pair per transaction.
//   csr_write_en / csr_write_data set decrypt mode; the user must write it
//   only when idle, the block does not enforce this.
// sequence
//   clear, key character and a text letter that only waits for its partner
//   are done in the idle state. finish key walks all 26 letters, one per cycle.
//   a text transaction that completes a pair runs through position ram read,
//   key square ram read, output register load.
// reset
//   synchronous, active high: key square empty, no pending letter, encrypt.
//   ram contents are not cleared.
// stalls
//   the result sits in an output register; the next request is taken while
//   it waits. a pair that finds the register still full waits in the load
//   state until the receiver drops rsp_stall.

module playfair_digraph_cipher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_first_letter,
   output logic [6:0] rsp_second_letter,
   input  logic       csr_write_en,
   input  logic       csr_write_data
);

   import pfc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_CELL,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic                decrypt_ff, decrypt_in;
   logic [LETTERS-1:0]  used_ff, used_in;
   logic [CELL_W-1:0]   fill_ff, fill_in;
   logic [LETTER_W-1:0] walk_ff, walk_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [LETTER_W-1:0] pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [6:0]          rsp_first_ff, rsp_first_in;
   logic [6:0]          rsp_second_ff, rsp_second_in;

   logic       accept;
   letter_type req_letter;
   cmd_type    req_op;

   // key placement, shared by key characters and the finish walk
   logic                place_req;
   logic                place_do;
   logic [LETTER_W-1:0] place_letter;

   // position ram: letter -> cell
   logic                pos_rd_en;
   logic [LETTER_W-1:0] pos_rd_addr_a, pos_rd_addr_b;
   logic [CELL_W-1:0]   pos_rd_a, pos_rd_b;

   // key square ram: cell -> letter
   logic                ks_rd_en;
   logic [CELL_W-1:0]   ks_rd_addr_a, ks_rd_addr_b;
   logic [LETTER_W-1:0] ks_rd_a, ks_rd_b;

   rc_type a_rc, b_rc;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_letter = decode_letter(req_char_in);
   assign req_op     = cmd_type'(req_cmd);

   // pair rules on the looked-up cells
   assign a_rc = split_cell(pos_rd_a);
   assign b_rc = split_cell(pos_rd_b);

   always_comb begin
      if (a_rc.row == b_rc.row) begin
         // same row: shift along the row
         ks_rd_addr_a = cell_at(a_rc.row, step5(a_rc.col, decrypt_ff));
         ks_rd_addr_b = cell_at(b_rc.row, step5(b_rc.col, decrypt_ff));
      end else if (a_rc.col == b_rc.col) begin
         // same column: shift along the column
         ks_rd_addr_a = cell_at(step5(a_rc.row, decrypt_ff), a_rc.col);
         ks_rd_addr_b = cell_at(step5(b_rc.row, decrypt_ff), b_rc.col);
      end else begin
         // rectangle: swap columns
         ks_rd_addr_a = cell_at(a_rc.row, b_rc.col);
         ks_rd_addr_b = cell_at(b_rc.row, a_rc.col);
      end
   end

   always_comb begin
      state_in      = state_ff;
      decrypt_in    = decrypt_ff;
      used_in       = used_ff;
      fill_in       = fill_ff;
      walk_in       = walk_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      pos_rd_en     = 1'b0;
      pos_rd_addr_a = fold_j(pend_ff);
      pos_rd_addr_b = LETTER_X;
      ks_rd_en      = 1'b0;
      place_req     = 1'b0;
      place_letter  = fold_j(req_letter.idx);

      if (csr_write_en) begin
         decrypt_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  CMD_CLEAR: begin
                     used_in       = '0;
                     fill_in       = '0;
                     pend_valid_in = 1'b0;
                     pend_in       = '0;
                  end
                  CMD_KEY: begin
                     place_req = req_letter.ok;
                  end
                  CMD_FINISH: begin
                     walk_in  = '0;
                     state_in = ST_FILL;
                  end
                  CMD_TEXT: begin
                     if (req_letter.ok) begin
                        if (!pend_valid_ff) begin
                           pend_valid_in = 1'b1;
                           pend_in       = req_letter.idx;
                        end else if (!decrypt_ff && pend_ff == req_letter.idx) begin
                           // doubled letter: code with x, keep the letter pending
                           pos_rd_en = 1'b1;
                           state_in  = ST_CELL;
                        end else begin
                           pos_rd_en     = 1'b1;
                           pos_rd_addr_b = fold_j(req_letter.idx);
                           pend_valid_in = 1'b0;
                           pend_in       = '0;
                           state_in      = ST_CELL;
                        end
                     end
                  end
                  CMD_END: begin
                     // lone letter is padded with x in encrypt, dropped in decrypt
                     if (pend_valid_ff && !decrypt_ff) begin
                        pos_rd_en = 1'b1;
                        state_in  = ST_CELL;
                     end
                     pend_valid_in = 1'b0;
                     pend_in       = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            place_req    = (walk_ff != LETTER_J);
            place_letter = walk_ff;
            if (walk_ff == LETTER_Z) begin
               state_in = ST_IDLE;
            end else begin
               walk_in = walk_ff + 5'd1;
            end
         end
         ST_CELL: begin
            ks_rd_en = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // load once the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = ASCII_LOWER_A + {2'b00, ks_rd_a};
               rsp_second_in = ASCII_LOWER_A + {2'b00, ks_rd_b};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      place_do = place_req && !used_ff[place_letter] && (fill_ff != FILL_FULL);
      if (place_do) begin
         used_in[place_letter] = 1'b1;
         fill_in               = fill_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         decrypt_ff    <= 1'b0;
         used_ff       <= '0;
         fill_ff       <= '0;
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         decrypt_ff    <= decrypt_in;
         used_ff       <= used_in;
         fill_ff       <= fill_in;
         walk_ff       <= walk_in;
         pend_valid_ff <= pend_valid_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   pfc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (LETTERS)
   ) u_pos_ram (
      .clock     (clock),
      .wr_en     (place_do),
      .wr_addr   (place_letter),
      .wr_data   (fill_ff),
      .rd_en     (pos_rd_en),
      .rd_addr_a (pos_rd_addr_a),
      .rd_addr_b (pos_rd_addr_b),
      .rd_data_a (pos_rd_a),
      .rd_data_b (pos_rd_b)
   );

   pfc_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (CELLS)
   ) u_square_ram (
      .clock     (clock),
      .wr_en     (place_do),
      .wr_addr   (fill_ff),
      .wr_data   (place_letter),
      .rd_en     (ks_rd_en),
      .rd_addr_a (ks_rd_addr_a),
      .rd_addr_b (ks_rd_addr_b),
      .rd_data_a (ks_rd_a),
      .rd_data_b (ks_rd_b)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_letter  = rsp_first_ff;
   assign rsp_second_letter = rsp_second_ff;

   // every placed letter is marked used exactly once
   assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == 32'(fill_ff))
      else $error("used letters and fill count disagree");

   // the square never holds more than 25 letters
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("key square overfilled");

   // a square read always follows a position read
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CELL |-> $past(pos_rd_en))
      else $error("cell state without position lookup");

   // a new response is only produced from the load state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside load state");

endmodule

// ===== hw/rtl/pfc_ram.sv =====
// pfc_ram: generic synchronous ram, one write port and two registered read ports
// standalone, no package needed

module pfc_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 25,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== bench/pfc_pair_checker.sv =====
`timescale 1ns / 100ps
// pfc_pair_checker: watches the request, response and csr ports of the playfair block,
// predicts every coded pair and compares it with the response; depends on pfc_pkg

module pfc_pair_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_char_in,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [6:0] rsp_first_letter,
   input  logic [6:0] rsp_second_letter,
   input  logic       csr_write_en,
   input  logic       csr_write_data,
   output int         mismatch_count,
   output int         pairs_outstanding,
   output int         pairs_checked
);
   import pfc_pkg::*;

   typedef struct packed {
      logic [6:0] first;
      logic [6:0] second;
   } coded_pair_type;

   // shadow copy of the key square and the cipher state
   logic [LETTER_W-1:0] square_cell [CELLS];
   logic [CELL_W-1:0]   cell_of_letter [LETTERS];
   logic                letter_placed [LETTERS];
   int                  cells_filled;
   logic                half_pair_held;
   logic [LETTER_W-1:0] held_letter;
   logic                decrypting;
   coded_pair_type      expected_pairs [$];

   // letter index 0..25 for either case, -1 otherwise
   function automatic int letter_index(input logic [7:0] ch);
      if (ch >= 8'h61 && ch <= 8'h7a) return int'(ch) - 8'h61;
      if (ch >= 8'h41 && ch <= 8'h5a) return int'(ch) - 8'h41;
      return -1;
   endfunction

   function automatic void place_letter(input logic [LETTER_W-1:0] l);
      if (letter_placed[l] || cells_filled >= CELLS) return;
      letter_placed[l]             = 1'b1;
      square_cell[cells_filled]    = l;
      cell_of_letter[l]            = CELL_W'(cells_filled);
      cells_filled++;
   endfunction

   function automatic logic [6:0] letter_at(input int row, input int col);
      return ASCII_LOWER_A + 7'(square_cell[(row % 5) * 5 + (col % 5)]);
   endfunction

   function automatic coded_pair_type code_digraph(input logic [LETTER_W-1:0] a,
                                                   input logic [LETTER_W-1:0] b);
      coded_pair_type r;
      int pa, pb, row_a, col_a, row_b, col_b, shift;
      pa    = int'(cell_of_letter[(a == LETTER_J) ? LETTER_I : a]) % CELLS;
      pb    = int'(cell_of_letter[(b == LETTER_J) ? LETTER_I : b]) % CELLS;
      row_a = pa / 5;
      col_a = pa % 5;
      row_b = pb / 5;
      col_b = pb % 5;
      // one step back is four steps forward around a side of five
      shift = decrypting ? 4 : 1;
      if (row_a == row_b) begin
         r.first  = letter_at(row_a, col_a + shift);
         r.second = letter_at(row_b, col_b + shift);
      end else if (col_a == col_b) begin
         r.first  = letter_at(row_a + shift, col_a);
         r.second = letter_at(row_b + shift, col_b);
      end else begin
         r.first  = letter_at(row_a, col_b);
         r.second = letter_at(row_b, col_a);
      end
      return r;
   endfunction

   function automatic void take_request(input logic [2:0] cmd, input logic [7:0] ch);
      int                  idx;
      logic [LETTER_W-1:0] l;
      idx = letter_index(ch);
      l   = idx[LETTER_W-1:0];
      case (cmd)
         CMD_CLEAR: begin
            foreach (letter_placed[i]) letter_placed[i] = 1'b0;
            cells_filled   = 0;
            half_pair_held = 1'b0;
            held_letter    = '0;
         end
         CMD_KEY: begin
            if (idx >= 0) place_letter((l == LETTER_J) ? LETTER_I : l);
         end
         CMD_FINISH: begin
            for (int i = 0; i < LETTERS; i++)
               if (i != LETTER_J) place_letter(LETTER_W'(i));
         end
         CMD_TEXT: begin
            if (idx >= 0) begin
               if (!half_pair_held) begin
                  half_pair_held = 1'b1;
                  held_letter    = l;
               end else if (!decrypting && held_letter == l) begin
                  // doubled letter: pad with x, second letter opens the next pair
                  expected_pairs.push_back(code_digraph(held_letter, LETTER_X));
                  held_letter = l;
               end else begin
                  expected_pairs.push_back(code_digraph(held_letter, l));
                  half_pair_held = 1'b0;
                  held_letter    = '0;
               end
            end
         end
         CMD_END: begin
            if (half_pair_held && !decrypting)
               expected_pairs.push_back(code_digraph(held_letter, LETTER_X));
            half_pair_held = 1'b0;
            held_letter    = '0;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      coded_pair_type want;
      if (reset) begin
         foreach (square_cell[i]) square_cell[i] = '0;
         foreach (cell_of_letter[i]) cell_of_letter[i] = '0;
         foreach (letter_placed[i]) letter_placed[i] = 1'b0;
         cells_filled   = 0;
         half_pair_held = 1'b0;
         held_letter    = '0;
         decrypting     = 1'b0;
         expected_pairs.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected pair %h %h with nothing expected",
                           $time, rsp_first_letter, rsp_second_letter);
               mismatch_count++;
            end else begin
               want = expected_pairs.pop_front();
               pairs_checked++;
               if (want.first !== rsp_first_letter || want.second !== rsp_second_letter) begin
                  if (mismatch_count < 10)
                     $display("%0t: pair mismatch, first exp %h got %h, second exp %h got %h",
                              $time, want.first, rsp_first_letter,
                              want.second, rsp_second_letter);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_en) decrypting = csr_write_data;
         if (req_valid && !req_stall) take_request(req_cmd, req_char_in);
      end
      pairs_outstanding = expected_pairs.size();
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: stimulus, idling and verdict for playfair_digraph_cipher
// depends on pfc_pkg, the block itself and pfc_pair_checker

module tb_top;
   import pfc_pkg::*;

   localparam int PHASE_ITEMS    = 240;   // request transactions per phase
   localparam int HOLD_OFF_RUN   = 200;   // long receiver hold-off, in cycles
   localparam int SETTLE_CYCLES  = 32;    // settle time after a finish key, which walks all 26 letters
   localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles: hold-off plus settle, many times

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_cmd = CMD_CLEAR;
   logic [7:0] req_char_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_first_letter;
   logic [6:0] rsp_second_letter;
   logic       csr_write_en = 1'b0;
   logic       csr_write_data = 1'b0;

   int mismatch_count;
   int pairs_outstanding;
   int pairs_checked;

   // idling odds of the current phase, in percent
   int send_gap_pct = 0;
   int stall_pct    = 0;
   bit hold_off_req = 1'b0;

   int items_sent    = 0;
   int working_items = 0;
   int mode_writes   = 0;
   int hold_offs     = 0;
   int quiet_cycles  = 0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   playfair_digraph_cipher u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_char_in       (req_char_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_first_letter  (rsp_first_letter),
      .rsp_second_letter (rsp_second_letter),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   pfc_pair_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_char_in       (req_char_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_first_letter  (rsp_first_letter),
      .rsp_second_letter (rsp_second_letter),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .pairs_outstanding (pairs_outstanding),
      .pairs_checked     (pairs_checked)
   );

   function automatic bit is_letter(input logic [7:0] ch);
      return (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
   endfunction

   // random letter, uppercase 30 percent of the time
   function automatic logic [7:0] any_letter();
      logic [7:0] base;
      base = ($urandom_range(99) < 30) ? 8'h41 : 8'h61;
      return base + 8'($urandom_range(25));
   endfunction

   // random byte that is not a letter: digits, punctuation, control, high half
   function automatic logic [7:0] non_letter();
      logic [7:0] ch;
      do ch = 8'($urandom_range(255)); while (is_letter(ch));
      return ch;
   endfunction

   // one request transaction; payload changes at the falling edge, valid stays
   // up between back-to-back transactions so it is never dropped and raised in
   // the same step
   task automatic offer(input logic [2:0] cmd, input logic [7:0] ch);
      @(negedge clock);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_char_in <= ch;
      do @(posedge clock); while (req_stall);
      items_sent++;
      // key and text bytes that are not letters, and unused commands, do nothing
      if (cmd == CMD_CLEAR || cmd == CMD_FINISH || cmd == CMD_END ||
          ((cmd == CMD_KEY || cmd == CMD_TEXT) && is_letter(ch)))
         working_items++;
   endtask

   // decrypt mode write: only once the block has drained and settled
   task automatic write_mode(input logic mode);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pairs_outstanding != 0) @(negedge clock);
      // a finish key may still be walking the alphabet with nothing to show
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= mode;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      mode_writes++;
   endtask

   // random traffic: mostly messages over the current key, some fresh keys,
   // some raw noise on any command code and any byte
   task automatic run_random(input int quota);
      int         goal;
      int         len;
      int         pick;
      logic [7:0] last;
      logic [7:0] ch;
      goal = items_sent + quota;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // new keyword; long ones overflow the square
            offer(CMD_CLEAR, 8'($urandom_range(255)));
            len = $urandom_range(30);
            repeat (len)
               offer(CMD_KEY, ($urandom_range(99) < 85) ? any_letter() : non_letter());
            // now and then the key is left unfinished over the old square
            if ($urandom_range(9) != 0) offer(CMD_FINISH, 8'($urandom_range(255)));
         end else if (pick < 85) begin
            len  = $urandom_range(1, 14);
            last = any_letter();
            repeat (len) begin
               pick = $urandom_range(99);
               if (pick < 15)      ch = non_letter();
               else if (pick < 30) ch = last;            // doubled letter
               else if (pick < 35) ch = last ^ 8'h20;    // doubled, other case
               else                ch = any_letter();
               if (is_letter(ch)) last = ch;
               offer(CMD_TEXT, ch);
            end
            // messages sometimes run on into the next one
            if ($urandom_range(99) < 85) offer(CMD_END, 8'($urandom_range(255)));
         end else begin
            offer(3'($urandom_range(7)), 8'($urandom_range(255)));
         end
      end
   endtask

   // receiver: random stalls per phase, plus one long hold-off on request so
   // the output register fills and the block pushes back on its input
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_RUN) @(negedge clock);
            hold_off_req = 1'b0;
            hold_offs++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog: any cycle with a transaction on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d pairs still expected",
                  quiet_cycles, pairs_outstanding);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, encrypt mode from reset, no idling
      // nothing keyed yet: only ignored text, an empty end and unused codes
      offer(CMD_TEXT, 8'h23);
      offer(CMD_END, 8'hff);
      offer(3'd5, 8'hff);
      offer(3'd7, 8'h00);
      offer(CMD_CLEAR, 8'h00);
      // keyword with upper case, j folded to i, a digit and repeats
      offer(CMD_KEY, 8'h50);   // P
      offer(CMD_KEY, 8'h6c);   // l
      offer(CMD_KEY, 8'h61);   // a
      offer(CMD_KEY, 8'h79);   // y
      offer(CMD_KEY, 8'h4a);   // J, lands as i
      offer(CMD_KEY, 8'h31);   // 1, dropped
      offer(CMD_KEY, 8'h61);   // a again, skipped
      offer(CMD_KEY, 8'h69);   // i, already there through j
      offer(CMD_FINISH, 8'h00);
      offer(CMD_KEY, 8'h71);   // square full, ignored
      // plain pair, then a doubled letter across cases
      offer(CMD_TEXT, 8'h68);  // h
      offer(CMD_TEXT, 8'h69);  // i
      offer(CMD_TEXT, 8'h65);  // e
      offer(CMD_TEXT, 8'h45);  // E: e x, E waits
      offer(CMD_TEXT, 8'h69);  // i
      // j and i differ before folding and share a cell after it
      offer(CMD_TEXT, 8'h4a);  // J
      offer(CMD_TEXT, 8'h69);  // i
      // doubled x, then the lone x padded at the end
      offer(CMD_TEXT, 8'h78);
      offer(CMD_TEXT, 8'h78);
      offer(CMD_END, 8'h00);
      // lone letter with noise in between, padded at the end
      offer(CMD_TEXT, 8'h61);
      offer(CMD_TEXT, 8'h7e);
      offer(CMD_END, 8'h80);

      // phase 0: no idling apart from one long receiver hold-off, encrypt
      hold_off_req = 1'b1;
      run_random(PHASE_ITEMS);

      // phase 1: decrypt, sender idles often
      write_mode(1'b1);
      send_gap_pct = 58;
      stall_pct    = 0;
      run_random(PHASE_ITEMS);

      // phase 2: back to encrypt, receiver stalls often
      write_mode(1'b0);
      send_gap_pct = 0;
      stall_pct    = 58;
      run_random(PHASE_ITEMS);

      // phase 3: decrypt, light idling on both sides
      write_mode(1'b1);
      send_gap_pct = 12;
      stall_pct    = 12;
      run_random(PHASE_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pairs_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("run summary: %0d request transactions, %0d of them doing work, over",
               items_sent, working_items);
      $display("four idling phases; %0d pairs checked, %0d mode writes, %0d hold-off",
               pairs_checked, mode_writes, hold_offs);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_ram.sv
hw/rtl/playfair_digraph_cipher.sv
bench/pfc_pair_checker.sv
bench/tb_top.sv
